/* rtl/gsq_pkg.sv */
package gsq_pkg;

  // Sizes of the channel store
  localparam int CHANNELS  = 16;
  localparam int MAX_STEPS = 32;
  localparam int CH_W      = $clog2(CHANNELS);
  localparam int POS_W     = $clog2(MAX_STEPS);
  localparam int CNT_W     = CH_W + 1;
  localparam int VAL_W     = POS_W + 1;
  localparam int MASK_W    = 16;

  // Configuration port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  typedef logic [CH_W-1:0]       chan_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [VAL_W-1:0]      val_t;
  typedef logic [MAX_STEPS-1:0]  pattern_t;
  typedef logic [MASK_W-1:0]     mask_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Register indexes on the configuration port
  localparam cfg_idx_t REG_CHANNEL_COUNT     = 2'd0;
  localparam cfg_idx_t REG_STEP_COUNT        = 2'd1;
  localparam cfg_idx_t REG_ROTATE_OFFSET     = 2'd2;
  localparam cfg_idx_t REG_RECORD_FROM_LEVEL = 2'd3;

  // Register reset values
  localparam cnt_t RST_CHANNEL_COUNT = cnt_t'(1);
  localparam val_t RST_STEP_COUNT    = val_t'(16);

  // Result of the shared compare and subtract unit
  typedef struct packed {
    logic ge;
    val_t diff;
  } sub_res_t;

endpackage

/* rtl/gsq_tick_if.sv */
interface gsq_tick_if;
  import gsq_pkg::*;

  logic valid;
  logic ready;
  logic clock_edge;
  logic reset_edge;
  logic clear_press;
  logic record_toggle;
  logic record_level;
  logic manual_bit;

  modport source (
    output valid, clock_edge, reset_edge, clear_press, record_toggle, record_level,
    output manual_bit,
    input  ready
  );

  modport sink (
    input  valid, clock_edge, reset_edge, clear_press, record_toggle, record_level,
    input  manual_bit,
    output ready
  );
endinterface

/* rtl/gsq_result_if.sv */
interface gsq_result_if;
  import gsq_pkg::*;

  logic  valid;
  logic  ready;
  mask_t trigger_mask;
  mask_t gate_mask;
  logic  record_on;
  pos_t  lead_step;

  modport source (
    output valid, trigger_mask, gate_mask, record_on, lead_step,
    input  ready
  );

  modport sink (
    input  valid, trigger_mask, gate_mask, record_on, lead_step,
    output ready
  );
endinterface

/* rtl/gsq_modsub.sv */
module gsq_modsub (
  input  gsq_pkg::val_t     value,
  input  gsq_pkg::val_t     modulus,
  output gsq_pkg::sub_res_t res
);
  import gsq_pkg::*;

  // One reduction step: compare against the modulus and subtract it once.
  always_comb begin
    res.ge   = (value >= modulus);
    res.diff = value - modulus;
  end
endmodule

/* rtl/polyphonic_gate_step_sequencer_core.sv */
// Gate step sequencer over up to sixteen channels. Each tick transfer is worked on alone:
// the block takes it in S_IDLE; when the tick carries a reset, S_START subtracts the step
// count from the rotate offset until it is below it; then each active channel passes
// through S_LOAD and S_REDUCE, which wraps its step position on a clock; then S_EMIT loads
// the result register. All modulo work goes through a single compare and subtract unit.
// A new tick is taken once the previous one has finished; a result that is still waiting
// in the output register does not block it, but that tick then holds in S_EMIT until the
// register is free. Configuration writes take effect from the next tick.
module polyphonic_gate_step_sequencer_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  write_en,
  input  gsq_pkg::cfg_idx_t     write_index,
  input  gsq_pkg::cfg_data_t    write_data,
  gsq_tick_if.sink              tick,
  gsq_result_if.source          result
);
  import gsq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_LOAD,
    S_REDUCE,
    S_EMIT
  } state_t;

  state_t   state;

  // Configuration registers
  cnt_t     channel_count;
  val_t     step_count;
  pos_t     rotate_offset;
  logic     record_from_level;

  // Channel store
  pattern_t pattern [CHANNELS];
  pos_t     position [CHANNELS];
  logic     record_flag;

  // Working registers of the current tick
  logic     t_clk;
  logic     t_rst;
  logic     t_clr;
  logic     t_man;
  cnt_t     nch;
  val_t     nst;
  chan_t    ch;
  val_t     acc;
  pos_t     start_pos;
  mask_t    trig_acc;
  mask_t    gate_acc;

  // Output register
  logic     out_valid;
  mask_t    out_trig;
  mask_t    out_gate;
  logic     out_rec;
  pos_t     out_lead;

  cnt_t     nch_sat;
  val_t     nst_sat;
  sub_res_t sub;
  pattern_t pat_next;
  pos_t     base_pos;
  pos_t     new_pos;
  logic     new_bit;
  logic     last_ch;
  logic     out_free;

  // Saturate the register values to their working ranges.
  always_comb begin
    nch_sat = channel_count;
    if (channel_count == '0) begin
      nch_sat = cnt_t'(1);
    end else if (channel_count > cnt_t'(CHANNELS)) begin
      nch_sat = cnt_t'(CHANNELS);
    end
    nst_sat = step_count;
    if (step_count == '0) begin
      nst_sat = val_t'(1);
    end else if (step_count > val_t'(MAX_STEPS)) begin
      nst_sat = val_t'(MAX_STEPS);
    end
  end

  gsq_modsub u_modsub (
    .value   (acc),
    .modulus (nst),
    .res     (sub)
  );

  // Channel update once its position has been reduced.
  always_comb begin
    base_pos = t_rst ? start_pos : position[ch];
    new_pos  = acc[POS_W-1:0];
    pat_next = t_clr ? '0 : pattern[ch];
    if (t_clk && record_flag) begin
      pat_next[new_pos] = t_man;
    end
    new_bit  = pat_next[new_pos];
    last_ch  = (ch == chan_t'(nch - cnt_t'(1)));
    out_free = !out_valid || result.ready;
  end

  assign tick.ready = (state == S_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count     <= RST_CHANNEL_COUNT;
      step_count        <= RST_STEP_COUNT;
      rotate_offset     <= '0;
      record_from_level <= 1'b0;
    end else if (write_en) begin
      unique case (write_index)
        REG_CHANNEL_COUNT:     channel_count     <= write_data[CNT_W-1:0];
        REG_STEP_COUNT:        step_count        <= write_data[VAL_W-1:0];
        REG_ROTATE_OFFSET:     rotate_offset     <= write_data[POS_W-1:0];
        REG_RECORD_FROM_LEVEL: record_from_level <= write_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer, channel store and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      record_flag <= 1'b0;
      out_valid   <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        pattern[i]  <= '0;
        position[i] <= '0;
      end
    end else begin
      // The output register fills when a tick finishes and empties on a transfer.
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (tick.valid) begin
            t_clk    <= tick.clock_edge;
            t_rst    <= tick.reset_edge;
            t_clr    <= tick.clear_press;
            t_man    <= tick.manual_bit;
            nch      <= nch_sat;
            nst      <= nst_sat;
            ch       <= '0;
            trig_acc <= '0;
            gate_acc <= '0;
            acc      <= {1'b0, rotate_offset};
            if (record_from_level) begin
              record_flag <= tick.record_level;
            end else if (tick.record_toggle) begin
              record_flag <= !record_flag;
            end
            state <= tick.reset_edge ? S_START : S_LOAD;
          end
        end
        // Reduce the rotate offset modulo the step count.
        S_START: begin
          if (sub.ge) begin
            acc <= sub.diff;
          end else begin
            start_pos <= acc[POS_W-1:0];
            state     <= S_LOAD;
          end
        end
        S_LOAD: begin
          acc   <= t_clk ? ({1'b0, base_pos} + val_t'(1)) : {1'b0, base_pos};
          state <= S_REDUCE;
        end
        // Wrap the new position, then commit the channel.
        S_REDUCE: begin
          if (t_clk && sub.ge) begin
            acc <= sub.diff;
          end else begin
            position[ch] <= new_pos;
            pattern[ch]  <= pat_next;
            gate_acc[ch] <= new_bit;
            trig_acc[ch] <= t_clk && new_bit;
            ch           <= ch + chan_t'(1);
            state        <= last_ch ? S_EMIT : S_LOAD;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_trig  <= trig_acc;
            out_gate  <= gate_acc;
            out_rec   <= record_flag;
            out_lead  <= position[0];
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid        = out_valid;
  assign result.trigger_mask = out_trig;
  assign result.gate_mask    = out_gate;
  assign result.record_on    = out_rec;
  assign result.lead_step    = out_lead;
endmodule

/* test/tb_polyphonic_gate_step_sequencer_core.sv */
`timescale 1ns / 1ps

module tb_polyphonic_gate_step_sequencer_core;
  import gsq_pkg::*;

  // Cycles without any transfer before the run is declared hung
  localparam int QUIET_LIMIT = 5000;
  // Cycles the receiver refuses results during the back-pressure test
  localparam int HOLD_CYCLES = 300;
  // Longest tick: reset subtractions plus a full wrap on every channel
  localparam int DRAIN_CYCLES = 700;
  localparam int RANDOM_BLOCKS = 16;
  localparam int TICKS_PER_BLOCK = 40;

  // One tick as carried by the input channel, first field in the top bit
  typedef struct packed {
    logic clock_edge;
    logic reset_edge;
    logic clear_press;
    logic record_toggle;
    logic record_level;
    logic manual_bit;
  } tick_t;

  typedef struct packed {
    mask_t trigger_mask;
    mask_t gate_mask;
    logic  record_on;
    pos_t  lead_step;
  } result_t;

  localparam tick_t T_NONE = 6'b000000;
  localparam tick_t T_CLK  = 6'b100000;
  localparam tick_t T_RST  = 6'b010000;
  localparam tick_t T_CLR  = 6'b001000;
  localparam tick_t T_TOG  = 6'b000100;
  localparam tick_t T_LVL  = 6'b000010;
  localparam tick_t T_MAN  = 6'b000001;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_TICK,
    ROW_KNOWN
  } row_kind_t;

  typedef struct {
    row_kind_t kind;
    cfg_idx_t  idx;
    cfg_data_t data;
    tick_t     stim;
    result_t   want;
  } dir_row_t;

  localparam int DIR_ROWS = 34;

  // Directed sequence. Tick rows carry a register index only as filler.
  dir_row_t dir_rows [DIR_ROWS] = '{
    // Out of reset: one channel, sixteen steps, record off
    '{ROW_KNOWN, REG_CHANNEL_COUNT, 6'd0, T_NONE, '{16'h0000, 16'h0000, 1'b0, 5'd0}},
    '{ROW_KNOWN, REG_CHANNEL_COUNT, 6'd0, T_CLK, '{16'h0000, 16'h0000, 1'b0, 5'd1}},
    // Record on by the button, then write a set step
    '{ROW_KNOWN, REG_CHANNEL_COUNT, 6'd0, T_CLK | T_TOG | T_MAN,
      '{16'h0001, 16'h0001, 1'b1, 5'd2}},
    '{ROW_TICK, REG_CHANNEL_COUNT, 6'd0, T_CLK | T_MAN, '0},
    '{ROW_TICK, REG_CHANNEL_COUNT, 6'd0, T_CLK | T_LVL, '0},
    '{ROW_KNOWN, REG_CHANNEL_COUNT, 6'd0, T_RST, '{16'h0000, 16'h0000, 1'b1, 5'd0}},
    '{ROW_TICK, REG_CHANNEL_COUNT, 6'd0, T_CLK | T_MAN | T_RST, '0},
    '{ROW_KNOWN, REG_CHANNEL_COUNT, 6'd0, T_CLR | T_TOG, '{16'h0000, 16'h0000, 1'b0, 5'd1}},
    // Level mode: a button press is ignored
    '{ROW_CFG, REG_RECORD_FROM_LEVEL, 6'd1, T_NONE, '0},
    '{ROW_KNOWN, REG_CHANNEL_COUNT, 6'd0, T_TOG, '{16'h0000, 16'h0000, 1'b0, 5'd1}},
    '{ROW_TICK, REG_CHANNEL_COUNT, 6'd0, T_CLK | T_LVL | T_MAN | T_TOG, '0},
    // Channel and step counts above range, rotate at its top
    '{ROW_CFG, REG_CHANNEL_COUNT, 6'd31, T_NONE, '0},
    '{ROW_CFG, REG_STEP_COUNT, 6'd63, T_NONE, '0},
    '{ROW_CFG, REG_ROTATE_OFFSET, 6'd31, T_NONE, '0},
    '{ROW_KNOWN, REG_CHANNEL_COUNT, 6'd0, T_RST | T_CLK | T_LVL | T_MAN,
      '{16'hffff, 16'hffff, 1'b1, 5'd0}},
    '{ROW_TICK, REG_CHANNEL_COUNT, 6'd0, T_CLK | T_LVL | T_MAN, '0},
    '{ROW_TICK, REG_CHANNEL_COUNT, 6'd0, T_CLK | T_LVL, '0},
    // Inactive channels are neither cleared nor clocked
    '{ROW_CFG, REG_CHANNEL_COUNT, 6'd3, T_NONE, '0},
    '{ROW_TICK, REG_CHANNEL_COUNT, 6'd0, T_CLR | T_CLK | T_MAN | T_LVL, '0},
    // Zero channels, and a pattern cut short under the current position
    '{ROW_CFG, REG_CHANNEL_COUNT, 6'd0, T_NONE, '0},
    '{ROW_CFG, REG_STEP_COUNT, 6'd2, T_NONE, '0},
    '{ROW_TICK, REG_CHANNEL_COUNT, 6'd0, T_LVL, '0},
    '{ROW_TICK, REG_CHANNEL_COUNT, 6'd0, T_CLK | T_LVL | T_MAN, '0},
    // All channels back, zero steps
    '{ROW_CFG, REG_CHANNEL_COUNT, 6'd16, T_NONE, '0},
    '{ROW_CFG, REG_STEP_COUNT, 6'd0, T_NONE, '0},
    '{ROW_TICK, REG_CHANNEL_COUNT, 6'd0, T_CLK, '0},
    '{ROW_CFG, REG_ROTATE_OFFSET, 6'd7, T_NONE, '0},
    '{ROW_CFG, REG_STEP_COUNT, 6'd33, T_NONE, '0},
    '{ROW_TICK, REG_CHANNEL_COUNT, 6'd0, T_RST | T_TOG, '0},
    // Back to the button, then a rotate larger than the pattern
    '{ROW_CFG, REG_RECORD_FROM_LEVEL, 6'd0, T_NONE, '0},
    '{ROW_TICK, REG_CHANNEL_COUNT, 6'd0, T_TOG | T_CLK | T_MAN, '0},
    '{ROW_CFG, REG_STEP_COUNT, 6'd5, T_NONE, '0},
    '{ROW_CFG, REG_ROTATE_OFFSET, 6'd12, T_NONE, '0},
    '{ROW_TICK, REG_CHANNEL_COUNT, 6'd0, T_RST, '0}
  };

  logic clk;
  logic rst;
  logic write_en;
  cfg_idx_t write_index;
  cfg_data_t write_data;

  gsq_tick_if tick_ch ();
  gsq_result_if result_ch ();

  polyphonic_gate_step_sequencer_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data),
    .tick        (tick_ch),
    .result      (result_ch)
  );

  // Predicted sequencer state and register copies
  pattern_t seq_pattern [CHANNELS];
  pos_t seq_pos [CHANNELS];
  logic seq_recording;
  logic [4:0] cfg_channels;
  logic [5:0] cfg_steps;
  logic [4:0] cfg_rotate;
  logic cfg_from_level;

  result_t pending_results [$];
  int errors;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_request;
  logic level_now;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  // Applies one tick to the predicted state, in the order record, clear, reset,
  // clock, and returns the result the block should give for it.
  function automatic result_t advance_sequencer(input tick_t t);
    result_t r;
    int n_ch;
    int n_st;
    int start;
    int p;
    r = '0;
    n_ch = int'(cfg_channels);
    if (n_ch < 1) n_ch = 1;
    if (n_ch > CHANNELS) n_ch = CHANNELS;
    n_st = int'(cfg_steps);
    if (n_st < 1) n_st = 1;
    if (n_st > MAX_STEPS) n_st = MAX_STEPS;

    if (cfg_from_level) seq_recording = t.record_level;
    else if (t.record_toggle) seq_recording = ~seq_recording;

    if (t.clear_press)
      for (int c = 0; c < n_ch; c++) seq_pattern[c] = '0;

    if (t.reset_edge) begin
      start = int'(cfg_rotate) % n_st;
      for (int c = 0; c < n_ch; c++) seq_pos[c] = pos_t'(start);
    end

    // A position left beyond a shortened pattern wraps on the next clock.
    if (t.clock_edge) begin
      for (int c = 0; c < n_ch; c++) begin
        p = (int'(seq_pos[c]) + 1) % n_st;
        seq_pos[c] = pos_t'(p);
        if (seq_recording) seq_pattern[c][p] = t.manual_bit;
        if (seq_pattern[c][p] && c < MASK_W) r.trigger_mask[c] = 1'b1;
      end
    end

    for (int c = 0; c < n_ch && c < MASK_W; c++)
      r.gate_mask[c] = seq_pattern[c][seq_pos[c]];
    r.record_on = seq_recording;
    r.lead_step = seq_pos[0];
    return r;
  endfunction

  // Register write on the configuration port, mirrored into the predictor
  task automatic cfg_write(input cfg_idx_t idx, input cfg_data_t data);
    write_en <= 1'b1;
    write_index <= idx;
    write_data <= data;
    @(posedge clk);
    write_en <= 1'b0;
    case (idx)
      REG_CHANNEL_COUNT:     cfg_channels = data[4:0];
      REG_STEP_COUNT:        cfg_steps = data;
      REG_ROTATE_OFFSET:     cfg_rotate = data[4:0];
      REG_RECORD_FROM_LEVEL: cfg_from_level = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Stops offering ticks and waits until every result has been taken.
  task automatic wait_idle();
    tick_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Offers one tick, with random idle cycles first, and records the result
  // it should produce once the transfer has happened.
  task automatic offer_tick(input tick_t t, input bit known, input result_t want);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.clock_edge <= t.clock_edge;
    tick_ch.reset_edge <= t.reset_edge;
    tick_ch.clear_press <= t.clear_press;
    tick_ch.record_toggle <= t.record_toggle;
    tick_ch.record_level <= t.record_level;
    tick_ch.manual_bit <= t.manual_bit;
    @(posedge clk);
    while (tick_ch.ready !== 1'b1) @(posedge clk);
    predicted = advance_sequencer(t);
    pending_results.push_back(known ? want : predicted);
  endtask

  // Ticks weighted towards clocking, with the record level held for stretches
  function automatic tick_t random_tick();
    tick_t t;
    if ($urandom_range(99) < 15) level_now = ~level_now;
    t.clock_edge = ($urandom_range(99) < 65);
    t.reset_edge = ($urandom_range(99) < 10);
    t.clear_press = ($urandom_range(99) < 6);
    t.record_toggle = ($urandom_range(99) < 15);
    t.record_level = level_now;
    t.manual_bit = 1'($urandom_range(1));
    return t;
  endfunction

  // Register value: often one of the given extremes, otherwise any 6-bit value
  function automatic cfg_data_t pick_setting(input cfg_data_t lo, input cfg_data_t hi);
    int roll;
    roll = $urandom_range(3);
    if (roll == 0) return lo;
    if (roll == 1) return hi;
    return cfg_data_t'($urandom_range(63));
  endfunction

  // Compares a transferred result with the oldest prediction.
  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      report_error($sformatf("result with no tick pending: trigger %h gate %h",
                             result_ch.trigger_mask, result_ch.gate_mask));
      return;
    end
    want = pending_results.pop_front();
    if (result_ch.trigger_mask !== want.trigger_mask)
      report_error($sformatf("trigger_mask %h, expected %h",
                             result_ch.trigger_mask, want.trigger_mask));
    if (result_ch.gate_mask !== want.gate_mask)
      report_error($sformatf("gate_mask %h, expected %h",
                             result_ch.gate_mask, want.gate_mask));
    if (result_ch.record_on !== want.record_on)
      report_error($sformatf("record_on %b, expected %b",
                             result_ch.record_on, want.record_on));
    if (result_ch.lead_step !== want.lead_step)
      report_error($sformatf("lead_step %0d, expected %0d",
                             result_ch.lead_step, want.lead_step));
  endtask

  // Result side: random stalls, and one long hold-off on request.
  initial begin : result_side
    int hold_left;
    hold_left = 0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk);
      if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) check_result();
    end
  end

  // Watchdog on cycles without any transfer on either channel.
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst === 1'b1 || (tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1) ||
        (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst = 1'b1;
    write_en = 1'b0;
    write_index = REG_CHANNEL_COUNT;
    write_data = '0;
    tick_ch.valid = 1'b0;
    tick_ch.clock_edge = 1'b0;
    tick_ch.reset_edge = 1'b0;
    tick_ch.clear_press = 1'b0;
    tick_ch.record_toggle = 1'b0;
    tick_ch.record_level = 1'b0;
    tick_ch.manual_bit = 1'b0;
    result_ch.ready = 1'b0;
    errors = 0;
    hold_request = 1'b0;
    level_now = 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 71;

    // Predicted state after reset
    for (int c = 0; c < CHANNELS; c++) begin
      seq_pattern[c] = '0;
      seq_pos[c] = '0;
    end
    seq_recording = 1'b0;
    cfg_channels = 5'(RST_CHANNEL_COUNT);
    cfg_steps = 6'(RST_STEP_COUNT);
    cfg_rotate = '0;
    cfg_from_level = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG: begin
          wait_idle();
          cfg_write(dir_rows[i].idx, dir_rows[i].data);
        end
        ROW_KNOWN: offer_tick(dir_rows[i].stim, 1'b1, dir_rows[i].want);
        default:   offer_tick(dir_rows[i].stim, 1'b0, '0);
      endcase
    end

    // Random ticks in blocks, each under fresh register settings
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      wait_idle();
      if (blk < 5) begin
        send_idle_pct = 16;
        recv_idle_pct = 71;
      end else if (blk < 10) begin
        send_idle_pct = 71;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      cfg_write(REG_CHANNEL_COUNT, pick_setting(6'd1, 6'd16));
      cfg_write(REG_STEP_COUNT, pick_setting(6'd1, 6'd32));
      cfg_write(REG_ROTATE_OFFSET, pick_setting(6'd0, 6'd31));
      cfg_write(REG_RECORD_FROM_LEVEL, cfg_data_t'($urandom_range(63)));
      // Results are refused for a long stretch while ticks keep coming.
      if (blk == 12) hold_request = 1'b1;
      repeat (TICKS_PER_BLOCK) offer_tick(random_tick(), 1'b0, '0);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_results.size()));

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
